// ===== design/ascii_frame_current_to_distance_assert.svh =====
// Assertion macros shared by the converter RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef ASCII_FRAME_CURRENT_TO_DISTANCE_ASSERT_SVH
`define ASCII_FRAME_CURRENT_TO_DISTANCE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AFCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afcd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define AFCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afcd assertion failed");

`endif

// ===== design/afcd_pkg.sv =====
// Package for the serial current-frame to distance converter.
// Holds widths, character codes, state types and the decimal scale table.
`default_nettype none

package afcd_pkg;

  localparam int MAX_FRACTION_DIGITS = 6;
  localparam int MAX_FRAME_CHARS     = 128;

  localparam int BYTE_W   = 8;
  localparam int DIST_W   = 16;
  localparam int CFG_A_W  = 8;
  localparam int OUT_W    = 32;
  localparam int MANT_W   = 30;
  localparam int FD_W     = 4;
  localparam int CNT_W    = $clog2(MAX_FRAME_CHARS);
  localparam int SCALE_W  = 30;
  localparam int SPAN_W   = DIST_W + 1;
  localparam int SM_W     = MANT_W + 1;
  localparam int DIFF_W   = SCALE_W + 4;
  localparam int PROD_W   = SPAN_W + DIFF_W;
  localparam int NUM_W    = PROD_W + 1;
  localparam int MAG_W    = NUM_W - 1;
  localparam int DCNT_W   = $clog2(MAG_W + 1);

  localparam logic [BYTE_W-1:0] CH_S     = 8'h73;
  localparam logic [BYTE_W-1:0] CH_E     = 8'h65;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

  localparam logic [CFG_A_W-1:0] CFG_NEAR = 8'd0;
  localparam logic [CFG_A_W-1:0] CFG_FAR  = 8'd1;

  localparam logic [DIST_W-1:0] NEAR_RESET = 16'd140;
  localparam logic [DIST_W-1:0] FAR_RESET  = 16'd2050;

  localparam logic [MANT_W-1:0] MANT_MAX = {MANT_W{1'b1}};
  localparam logic [OUT_W-1:0]  OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0]  OUT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_SIGN = 3'd1,
    PH_INT  = 3'd2,
    PH_FRAC = 3'd3,
    PH_STOP = 3'd4
  } parse_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_BASE,
    ST_MUL_SPAN,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV,
    ST_FINISH
  } conv_state_t;

  // Parse result as seen by the arithmetic sequencer.
  typedef struct packed {
    logic [MANT_W-1:0] mantissa;
    logic [FD_W-1:0]   fdigits;
    logic              negative;
    logic              overflow;
  } parse_t;

  typedef struct packed {
    logic               start;
    logic [MAG_W-1:0]   dividend;
    logic [SCALE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quotient;
  } div_rsp_t;

  // Ten to the power f; anything above nine uses nine.
  function automatic logic [SCALE_W-1:0] dec_scale(input logic [FD_W-1:0] f);
    logic [SCALE_W-1:0] s;
    case (f)
      4'd0:    s = 30'd1;
      4'd1:    s = 30'd10;
      4'd2:    s = 30'd100;
      4'd3:    s = 30'd1000;
      4'd4:    s = 30'd10000;
      4'd5:    s = 30'd100000;
      4'd6:    s = 30'd1000000;
      4'd7:    s = 30'd10000000;
      4'd8:    s = 30'd100000000;
      default: s = 30'd1000000000;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== design/afcd_ifs.sv =====
// Handshake interfaces for the converter: received bytes, results and
// configuration writes. Depends on afcd_pkg for field widths.
`default_nettype none

interface afcd_in_if;
  logic                        valid;
  logic                        ready;
  logic [afcd_pkg::BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface afcd_out_if;
  logic                       valid;
  logic                       ready;
  logic [afcd_pkg::OUT_W-1:0] distance_q4;
  logic                       saturated;
  modport source (output valid, output distance_q4, output saturated, input ready);
  modport sink (input valid, input distance_q4, input saturated, output ready);
endinterface

interface afcd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [afcd_pkg::CFG_A_W-1:0] addr;
  logic [afcd_pkg::DIST_W-1:0]  data;
  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// ===== design/afcd_parser.sv =====
// Frame tracker and on-the-fly decimal parser, one byte per cycle.
// Depends on afcd_pkg.
`default_nettype none

module afcd_parser (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          take,
  input  wire [afcd_pkg::BYTE_W-1:0]   rx_byte,
  output afcd_pkg::parse_t             snap
);
  import afcd_pkg::*;

  logic              in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [MANT_W-1:0] mant_r, mant_nxt;
  logic [FD_W-1:0]   fd_r, fd_nxt;
  parse_phase_t      phase_r, phase_nxt;
  logic              neg_r, neg_nxt;
  logic              ovf_r, ovf_nxt;

  logic              is_digit;
  logic              is_space;
  logic [3:0]        digit;
  logic [MANT_W+3:0] times_ten;
  logic [MANT_W-1:0] dig_mant;
  logic              dig_ovf;
  logic [CNT_W:0]    count_inc;

  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_space  = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
  assign digit     = 4'(rx_byte - CH_ZERO);
  assign times_ten = {mant_r, 3'b000} + {2'b00, mant_r, 1'b0} + (MANT_W+4)'(digit);
  assign count_inc = {1'b0, count_r} + (CNT_W+1)'(1);

  // Digit accumulation; once the flag is up the mantissa holds at its maximum.
  always_comb begin
    if (ovf_r) begin
      dig_mant = mant_r;
      dig_ovf  = 1'b1;
    end else if (|times_ten[MANT_W+3:MANT_W]) begin
      dig_mant = MANT_MAX;
      dig_ovf  = 1'b1;
    end else begin
      dig_mant = times_ten[MANT_W-1:0];
      dig_ovf  = 1'b0;
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    mant_nxt     = mant_r;
    fd_nxt       = fd_r;
    phase_nxt    = phase_r;
    neg_nxt      = neg_r;
    ovf_nxt      = ovf_r;
    if (take) begin
      if (rx_byte == CH_E || (rx_byte == CH_S && !in_frame_r)) begin
        in_frame_nxt = (rx_byte == CH_S);
        count_nxt    = '0;
        mant_nxt     = '0;
        fd_nxt       = '0;
        phase_nxt    = PH_LEAD;
        neg_nxt      = 1'b0;
        ovf_nxt      = 1'b0;
      end else if (rx_byte != CH_S && in_frame_r) begin
        case (phase_r)
          PH_LEAD: begin
            if (is_space) begin
              phase_nxt = PH_LEAD;
            end else if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
              neg_nxt   = (rx_byte == CH_MINUS);
              phase_nxt = PH_SIGN;
            end else if (is_digit) begin
              mant_nxt  = dig_mant;
              ovf_nxt   = dig_ovf;
              phase_nxt = PH_INT;
            end else if (rx_byte == CH_POINT) begin
              phase_nxt = PH_FRAC;
            end else begin
              phase_nxt = PH_STOP;
            end
          end
          PH_SIGN, PH_INT: begin
            if (is_digit) begin
              mant_nxt  = dig_mant;
              ovf_nxt   = dig_ovf;
              phase_nxt = PH_INT;
            end else if (rx_byte == CH_POINT) begin
              phase_nxt = PH_FRAC;
            end else begin
              phase_nxt = PH_STOP;
            end
          end
          PH_FRAC: begin
            if (is_digit) begin
              if (!ovf_r && fd_r < FD_W'(MAX_FRACTION_DIGITS)) begin
                mant_nxt = dig_mant;
                ovf_nxt  = dig_ovf;
                if (!dig_ovf) begin
                  fd_nxt = fd_r + FD_W'(1);
                end
              end
            end else begin
              phase_nxt = PH_STOP;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
        if (count_inc >= (CNT_W+1)'(MAX_FRAME_CHARS)) begin
          in_frame_nxt = 1'b0;
          count_nxt    = '0;
        end else begin
          count_nxt = count_inc[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= '0;
      mant_r     <= '0;
      fd_r       <= '0;
      phase_r    <= PH_LEAD;
      neg_r      <= 1'b0;
      ovf_r      <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      mant_r     <= mant_nxt;
      fd_r       <= fd_nxt;
      phase_r    <= phase_nxt;
      neg_r      <= neg_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  assign snap.mantissa = mant_r;
  assign snap.fdigits  = fd_r;
  assign snap.negative = neg_r;
  assign snap.overflow = ovf_r;

endmodule

`default_nettype wire

// ===== design/afcd_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Divides an unsigned magnitude by the decimal scale; depends on afcd_pkg.
`default_nettype none

module afcd_div (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire afcd_pkg::div_req_t  req,
  output afcd_pkg::div_rsp_t       rsp
);
  import afcd_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SCALE_W-1:0] rem_r, rem_nxt;
  logic [SCALE_W-1:0] dvs_r, dvs_nxt;
  logic [MAG_W-1:0]   quo_r, quo_nxt;
  logic [SCALE_W:0]   trial;
  logic [SCALE_W:0]   diff;

  assign trial = {rem_r, quo_r[MAG_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(MAG_W);
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so it fits its width.
      if (!diff[SCALE_W]) begin
        rem_nxt = diff[SCALE_W-1:0];
        quo_nxt = {quo_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[SCALE_W-1:0];
        quo_nxt = {quo_r[MAG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// ===== design/ascii_frame_current_to_distance.sv =====
// Serial current-frame to distance converter, top level.
// Depends on afcd_pkg, afcd_ifs, afcd_parser, afcd_div and the assertion header.
//
// Bytes from the sensor link are parsed as they arrive while the block is
// idle. An 'e' starts the distance computation, which runs under a small
// sequencer on one shared 17 by 34 bit multiplier (two products and a sum,
// then a step to launch the divider) and then a bit-serial divider by the
// decimal scale, so after an 'e' no byte is accepted until the block is idle.
// The result sits in an output register, so the next byte is taken while it
// waits; a later 'e' holds in its last step until the earlier word has gone.
// Configuration writes are always ready.
`default_nettype none

module ascii_frame_current_to_distance (
  input  wire          clk,
  input  wire          rst_n,
  afcd_in_if.sink      in_chan,
  afcd_out_if.source   out_chan,
  afcd_cfg_if.sink     cfg_chan
);
  import afcd_pkg::*;

  `include "ascii_frame_current_to_distance_assert.svh"

  conv_state_t        state_r, state_nxt;
  logic [DIST_W-1:0]  near_r, far_r;
  parse_t             parse_snap;
  logic               in_acc;
  logic               e_acc;

  logic [SCALE_W-1:0]       scale_r, scale_nxt;
  logic signed [SM_W-1:0]   sm_r, sm_nxt;
  logic                     ovf_r, ovf_nxt;
  logic signed [SPAN_W-1:0] span_r, span_nxt;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [NUM_W-1:0]  base_r, base_nxt;
  logic signed [NUM_W-1:0]  num_r, num_nxt;
  logic                     numneg_r, numneg_nxt;

  logic signed [SPAN_W-1:0] mul_a;
  logic signed [DIFF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [NUM_W-1:0]  num_neg;

  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  dist_r, dist_nxt;
  logic              sat_r, sat_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign e_acc          = in_acc && (in_chan.rx_byte == CH_E);
  assign cfg_chan.ready = 1'b1;

  afcd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (in_acc),
    .rx_byte (in_chan.rx_byte),
    .snap    (parse_snap)
  );

  afcd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // The one multiplier: near times scale first, then span times the offset reading.
  always_comb begin
    if (state_r == ST_MUL_SPAN) begin
      mul_a = span_r;
      mul_b = diff_r;
    end else begin
      mul_a = $signed({1'b0, near_r});
      mul_b = $signed({{(DIFF_W-SCALE_W){1'b0}}, scale_r});
    end
  end
  assign mul_p   = mul_a * mul_b;
  assign num_neg = -num_r;

  assign div_req.start    = (state_r == ST_DIV_GO);
  assign div_req.dividend = num_r[NUM_W-1] ? num_neg[MAG_W-1:0] : num_r[MAG_W-1:0];
  assign div_req.divisor  = scale_r;

  always_comb begin
    state_nxt     = state_r;
    scale_nxt     = scale_r;
    sm_nxt        = sm_r;
    ovf_nxt       = ovf_r;
    span_nxt      = span_r;
    diff_nxt      = diff_r;
    prod_nxt      = prod_r;
    base_nxt      = base_r;
    num_nxt       = num_r;
    numneg_nxt    = numneg_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    dist_nxt      = dist_r;
    sat_nxt       = sat_r;
    case (state_r)
      ST_IDLE: begin
        if (e_acc) begin
          scale_nxt = dec_scale(parse_snap.fdigits);
          sm_nxt    = parse_snap.negative ? -$signed({1'b0, parse_snap.mantissa})
                                          : $signed({1'b0, parse_snap.mantissa});
          ovf_nxt   = parse_snap.overflow;
          state_nxt = ST_MUL_BASE;
        end
      end
      ST_MUL_BASE: begin
        prod_nxt  = mul_p;
        diff_nxt  = DIFF_W'(sm_r) - $signed({2'b00, scale_r, 2'b00});
        span_nxt  = $signed({1'b0, far_r}) - $signed({1'b0, near_r});
        state_nxt = ST_MUL_SPAN;
      end
      ST_MUL_SPAN: begin
        base_nxt  = NUM_W'(prod_r) <<< 4;
        prod_nxt  = mul_p;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        num_nxt   = base_r + NUM_W'(prod_r);
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        numneg_nxt = num_r[NUM_W-1];
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Truncation toward zero: divide the magnitude, then restore the sign.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          if (numneg_r) begin
            if (div_rsp.quotient > MAG_W'(OUT_MIN)) begin
              dist_nxt = OUT_MIN;
              sat_nxt  = 1'b1;
            end else begin
              dist_nxt = -div_rsp.quotient[OUT_W-1:0];
              sat_nxt  = ovf_r;
            end
          end else begin
            if (div_rsp.quotient > MAG_W'(OUT_MAX)) begin
              dist_nxt = OUT_MAX;
              sat_nxt  = 1'b1;
            end else begin
              dist_nxt = div_rsp.quotient[OUT_W-1:0];
              sat_nxt  = ovf_r;
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      near_r      <= NEAR_RESET;
      far_r       <= FAR_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        if (cfg_chan.addr == CFG_NEAR) begin
          near_r <= cfg_chan.data;
        end else if (cfg_chan.addr == CFG_FAR) begin
          far_r <= cfg_chan.data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    scale_r  <= scale_nxt;
    sm_r     <= sm_nxt;
    ovf_r    <= ovf_nxt;
    span_r   <= span_nxt;
    diff_r   <= diff_nxt;
    prod_r   <= prod_nxt;
    base_r   <= base_nxt;
    num_r    <= num_nxt;
    numneg_r <= numneg_nxt;
    dist_r   <= dist_nxt;
    sat_r    <= sat_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.distance_q4 = dist_r;
  assign out_chan.saturated   = sat_r;

  `AFCD_ASSERT_NEXT(a_e_starts_seq, e_acc, state_r == ST_MUL_BASE)
  `AFCD_ASSERT_NEXT(a_e_clears_parse, e_acc, parse_snap.mantissa == '0 && !parse_snap.overflow)
  `AFCD_ASSERT_NOW(a_div_done_in_wait, div_rsp.done, state_r == ST_DIV)
  `AFCD_ASSERT_NEXT(a_finish_loads, state_r == ST_FINISH && state_nxt == ST_IDLE, out_valid_r)

endmodule

`default_nettype wire
